>>> design/hill_cipher_3x3_decrypt_core_macros.svh
// assertion macros for the hill cipher 3x3 decrypt core
// no dependencies; included by the top level only
`ifndef HILL_CIPHER_3X3_DECRYPT_CORE_MACROS_SVH
`define HILL_CIPHER_3X3_DECRYPT_CORE_MACROS_SVH
`ifndef SYNTH
`define HCD_ASSERT_IMPLIES(name, clk, rst, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("hcd assertion failed");
`define HCD_ASSERT_NEXT(name, clk, rst, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("hcd assertion failed");
`else
`define HCD_ASSERT_IMPLIES(name, clk, rst, a, b)
`define HCD_ASSERT_NEXT(name, clk, rst, a, b)
`endif
`endif

>>> design/hcd_pkg.sv
// shared types, constants and modular arithmetic helpers for the decrypt core
// no dependencies
`default_nettype none
package hcd_pkg;

  localparam int MODULUS     = 26;
  localparam int LW          = 5;
  localparam int KW          = 9 * LW;
  localparam int RW          = 12;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = (1 << RECIP_SHIFT) / MODULUS;
  localparam int Q_DEPTH     = 2;
  localparam int QAW         = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW         = $clog2(Q_DEPTH + 1);

  localparam logic [RW-1:0] OFFSET    = RW'(MODULUS * (MODULUS - 1));
  localparam logic [KW-1:0] KEY_RESET = 45'd1099512676353;

  typedef logic [LW-1:0] letter_t;

  typedef struct packed {
    letter_t l2;
    letter_t l1;
    letter_t l0;
  } group_t;

  typedef struct packed {
    logic   push;
    group_t group;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_COF,
    B_ADJ,
    B_DET,
    B_DINV,
    B_INV,
    B_ROW,
    B_ERR
  } back_state_t;

  typedef letter_t inv_table_t [MODULUS];

  function automatic inv_table_t build_inv_table();
    inv_table_t tab;
    int a;
    int x;
    for (a = 0; a < MODULUS; a++) begin
      tab[a] = '0;
      for (x = MODULUS - 1; x >= 1; x--) begin
        if (((a * x) % MODULUS) == 1) tab[a] = LW'(x);
      end
    end
    return tab;
  endfunction

  localparam inv_table_t INV_TABLE = build_inv_table();

  // remainder by reciprocal multiply, one correction step
  function automatic letter_t mod_reduce(input logic [RW-1:0] x);
    logic [RW+RECIP_SHIFT-1:0] prod;
    logic [RW-1:0]             q;
    logic [RW-1:0]             r;
    prod = (RW + RECIP_SHIFT)'(x) * (RW + RECIP_SHIFT)'(RECIP);
    q    = prod[RW+RECIP_SHIFT-1:RECIP_SHIFT];
    r    = x - RW'(q * RW'(MODULUS));
    if (r >= RW'(MODULUS)) r = r - RW'(MODULUS);
    return r[LW-1:0];
  endfunction

  function automatic logic [RW-1:0] mul(input letter_t a, input letter_t b);
    return RW'(a) * RW'(b);
  endfunction

endpackage
`default_nettype wire

>>> design/hill_cipher_3x3_decrypt_core.sv
// hill cipher 3x3 decrypt core, modulo 26
// flow: the back end pops each queued group, steps through cofactor, adjugate, determinant
//   and inverse states, then emits three letters or a key error, and only then pops the next;
//   letters taken one per cycle until the two-group queue fills
// reset: synchronous, clears letter count, queue, sequencer and output valid;
//   key returns to the identity matrix
`default_nettype none
`include "hill_cipher_3x3_decrypt_core_macros.svh"
module hill_cipher_3x3_decrypt_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,   // [4:0] cipher_letter
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [7:0]                  m_tdata,   // [4:0] plain_letter
  output logic                        m_tlast,
  output logic                        m_tuser,   // [0] key_error
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [hcd_pkg::KW-1:0] cfg_data
);

  logic [hcd_pkg::KW-1:0] key;
  hcd_pkg::push_t         push;
  hcd_pkg::q_stat_t       q_stat;
  hcd_pkg::group_t        rd_group;
  logic                   pop;
  hcd_pkg::letter_t       out_letter;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) key <= hcd_pkg::KEY_RESET;
    else if (cfg_valid && cfg_ready) key <= cfg_data;
  end

  hcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_letter (s_tdata[hcd_pkg::LW-1:0]),
    .q_stat    (q_stat),
    .in_ready  (s_tready),
    .push      (push)
  );

  hcd_group_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .rd_group (rd_group),
    .q_stat   (q_stat)
  );

  hcd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .rd_group   (rd_group),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_letter (out_letter),
    .out_last   (m_tlast),
    .out_err    (m_tuser)
  );

  assign m_tdata = {(8 - hcd_pkg::LW)'(0), out_letter};

  `HCD_ASSERT_IMPLIES(a_err_result, clk, rst, m_tvalid && m_tuser, m_tlast && (m_tdata == 8'd0))
  `HCD_ASSERT_IMPLIES(a_letter_range, clk, rst, m_tvalid, m_tdata < 8'(hcd_pkg::MODULUS))
  `HCD_ASSERT_IMPLIES(a_no_push_full, clk, rst, push.push, !q_stat.full)
  `HCD_ASSERT_NEXT(a_pop_leaves_idle, clk, rst, pop, !pop)

endmodule
`default_nettype wire

>>> design/hcd_front.sv
// front end: collects ciphertext letters into groups of three
// depends on hcd_pkg
`default_nettype none
module hcd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire hcd_pkg::letter_t in_letter,
  input  wire hcd_pkg::q_stat_t q_stat,
  output logic                 in_ready,
  output hcd_pkg::push_t       push
);

  logic [1:0]       count;
  hcd_pkg::letter_t held [2];
  logic             accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign push.push     = accept && (count == 2'd2);
  assign push.group.l0 = held[0];
  assign push.group.l1 = held[1];
  assign push.group.l2 = in_letter;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      held[0] <= '0;
      held[1] <= '0;
    end else if (accept) begin
      if (count == 2'd2) begin
        count <= '0;
      end else begin
        held[count[0]] <= in_letter;
        count          <= count + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/hcd_group_fifo.sv
// short queue of complete letter groups between front and back
// depends on hcd_pkg
`default_nettype none
module hcd_group_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire hcd_pkg::push_t push,
  input  wire logic           pop,
  output hcd_pkg::group_t     rd_group,
  output hcd_pkg::q_stat_t    q_stat
);

  hcd_pkg::group_t                 mem [hcd_pkg::Q_DEPTH];
  logic [hcd_pkg::QAW-1:0]         wr_ptr;
  logic [hcd_pkg::QAW-1:0]         rd_ptr;
  logic [hcd_pkg::QCW-1:0]         cnt;
  logic                            do_push;
  logic                            do_pop;

  assign q_stat.full  = (cnt == hcd_pkg::QCW'(hcd_pkg::Q_DEPTH));
  assign q_stat.empty = (cnt == '0);
  assign do_push      = push.push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_group     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push.group;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == hcd_pkg::QAW'(hcd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == hcd_pkg::QAW'(hcd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) cnt <= cnt + 1'b1;
      else if (do_pop && !do_push) cnt <= cnt - 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> design/hcd_back.sv
// back end: key inverse sequencer, matrix product and output register
// depends on hcd_pkg
`default_nettype none
module hcd_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [hcd_pkg::KW-1:0]     key,
  input  wire hcd_pkg::group_t            rd_group,
  input  wire hcd_pkg::q_stat_t           q_stat,
  output logic                            pop,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output hcd_pkg::letter_t                out_letter,
  output logic                            out_last,
  output logic                            out_err
);

  hcd_pkg::back_state_t state;
  hcd_pkg::back_state_t state_next;
  logic [1:0]           row;
  hcd_pkg::letter_t     k    [9];
  hcd_pkg::letter_t     v    [3];
  logic [hcd_pkg::RW-1:0] cof [9];
  hcd_pkg::letter_t     adj  [9];
  logic [hcd_pkg::RW-1:0] det_raw;
  hcd_pkg::letter_t     dinv;
  hcd_pkg::letter_t     inv  [9];
  hcd_pkg::letter_t     sel  [3];
  logic [hcd_pkg::RW-1:0] row_sum;
  logic                 out_free;
  logic                 load_row;
  logic                 load_err;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      hcd_pkg::B_IDLE: if (!q_stat.empty) state_next = hcd_pkg::B_COF;
      hcd_pkg::B_COF:  state_next = hcd_pkg::B_ADJ;
      hcd_pkg::B_ADJ:  state_next = hcd_pkg::B_DET;
      hcd_pkg::B_DET:  state_next = hcd_pkg::B_DINV;
      hcd_pkg::B_DINV: begin
        if (hcd_pkg::INV_TABLE[hcd_pkg::mod_reduce(det_raw)] == '0) begin
          state_next = hcd_pkg::B_ERR;
        end else begin
          state_next = hcd_pkg::B_INV;
        end
      end
      hcd_pkg::B_INV:  state_next = hcd_pkg::B_ROW;
      hcd_pkg::B_ROW:  if (out_free && row == 2'd2) state_next = hcd_pkg::B_IDLE;
      hcd_pkg::B_ERR:  if (out_free) state_next = hcd_pkg::B_IDLE;
      default:         state_next = hcd_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_row = 1'b0;
    load_err = 1'b0;
    case (state)
      hcd_pkg::B_IDLE: pop = !q_stat.empty;
      hcd_pkg::B_ROW:  load_row = out_free;
      hcd_pkg::B_ERR:  load_err = out_free;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (row)
      2'd0:    begin sel[0] = inv[0]; sel[1] = inv[1]; sel[2] = inv[2]; end
      2'd1:    begin sel[0] = inv[3]; sel[1] = inv[4]; sel[2] = inv[5]; end
      default: begin sel[0] = inv[6]; sel[1] = inv[7]; sel[2] = inv[8]; end
    endcase
    row_sum = hcd_pkg::mul(sel[0], v[0]) + hcd_pkg::mul(sel[1], v[1])
            + hcd_pkg::mul(sel[2], v[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hcd_pkg::B_IDLE;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == hcd_pkg::B_INV) row <= '0;
      else if (load_row) row <= row + 2'd1;
      if (load_row || load_err) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < 9; i++) begin
        k[i] <= hcd_pkg::mod_reduce(hcd_pkg::RW'(key[i*hcd_pkg::LW +: hcd_pkg::LW]));
      end
      v[0] <= hcd_pkg::mod_reduce(hcd_pkg::RW'(rd_group.l0));
      v[1] <= hcd_pkg::mod_reduce(hcd_pkg::RW'(rd_group.l1));
      v[2] <= hcd_pkg::mod_reduce(hcd_pkg::RW'(rd_group.l2));
    end
    if (state == hcd_pkg::B_COF) begin
      cof[0] <= hcd_pkg::OFFSET + hcd_pkg::mul(k[4], k[8]) - hcd_pkg::mul(k[5], k[7]);
      cof[1] <= hcd_pkg::OFFSET + hcd_pkg::mul(k[2], k[7]) - hcd_pkg::mul(k[1], k[8]);
      cof[2] <= hcd_pkg::OFFSET + hcd_pkg::mul(k[1], k[5]) - hcd_pkg::mul(k[2], k[4]);
      cof[3] <= hcd_pkg::OFFSET + hcd_pkg::mul(k[5], k[6]) - hcd_pkg::mul(k[3], k[8]);
      cof[4] <= hcd_pkg::OFFSET + hcd_pkg::mul(k[0], k[8]) - hcd_pkg::mul(k[2], k[6]);
      cof[5] <= hcd_pkg::OFFSET + hcd_pkg::mul(k[2], k[3]) - hcd_pkg::mul(k[0], k[5]);
      cof[6] <= hcd_pkg::OFFSET + hcd_pkg::mul(k[3], k[7]) - hcd_pkg::mul(k[4], k[6]);
      cof[7] <= hcd_pkg::OFFSET + hcd_pkg::mul(k[1], k[6]) - hcd_pkg::mul(k[0], k[7]);
      cof[8] <= hcd_pkg::OFFSET + hcd_pkg::mul(k[0], k[4]) - hcd_pkg::mul(k[1], k[3]);
    end
    if (state == hcd_pkg::B_ADJ) begin
      for (int i = 0; i < 9; i++) adj[i] <= hcd_pkg::mod_reduce(cof[i]);
    end
    if (state == hcd_pkg::B_DET) begin
      det_raw <= hcd_pkg::mul(k[0], adj[0]) + hcd_pkg::mul(k[1], adj[3])
               + hcd_pkg::mul(k[2], adj[6]);
    end
    if (state == hcd_pkg::B_DINV) begin
      dinv <= hcd_pkg::INV_TABLE[hcd_pkg::mod_reduce(det_raw)];
    end
    if (state == hcd_pkg::B_INV) begin
      for (int i = 0; i < 9; i++) inv[i] <= hcd_pkg::mod_reduce(hcd_pkg::mul(dinv, adj[i]));
    end
    if (load_row) begin
      out_letter <= hcd_pkg::mod_reduce(row_sum);
      out_last   <= (row == 2'd2);
      out_err    <= 1'b0;
    end else if (load_err) begin
      out_letter <= '0;
      out_last   <= 1'b1;
      out_err    <= 1'b1;
    end
  end

endmodule
`default_nettype wire
